### design/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, widths and constants of the nearest point search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  // Field widths of the item channels
  localparam int IDX_FIELD_W = 4;
  localparam int COORD_W     = 16;
  localparam int RAD_W       = 16;
  localparam int DIST_W      = 16;
  localparam int CNT_FIELD_W = 5;

  // Squared radius fits in 32 bits after the clamp
  localparam int RSQ_W = 32;
  // One squared axis difference: 17-bit signed value squared
  localparam int SQ_W  = 33;
  // Sum of two squared differences
  localparam int D2_W  = 34;

  localparam logic [RAD_W-1:0] RADIUS_CAP = 16'd46340;

  // Default sizes
  localparam int ENTRIES_DEF     = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Request opcodes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } cmd_op_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_op_t                   op;
    logic [IDX_FIELD_W-1:0]    index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
    logic                      active;
    logic [RSQ_W-1:0]          rad_sq;
  } cmd_t;

  // Square root unit handshake
  typedef struct packed {
    logic             start;
    logic [RSQ_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] root;
  } sqrt_rsp_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_ROOT = 3'b100
  } back_state_t;

endpackage : nps_pkg

`default_nettype wire

### design/nps_if.sv
// ----------------------------------------------------------------------------
// nps_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_req_if;
  import nps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [IDX_FIELD_W-1:0]    entry_index;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_z;
  logic                      entry_active;
  logic [RAD_W-1:0]          search_radius;

  modport source (
    output valid, req_type, entry_index, pos_x, pos_z, entry_active, search_radius,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, pos_x, pos_z, entry_active, search_radius,
    output ready
  );
endinterface : nps_req_if

interface nps_rsp_if;
  import nps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [IDX_FIELD_W-1:0] nearest_index;
  logic [DIST_W-1:0]      distance;
  logic [CNT_FIELD_W-1:0] active_total;

  modport source (
    output valid, found, nearest_index, distance, active_total,
    input  ready
  );

  modport sink (
    input  valid, found, nearest_index, distance, active_total,
    output ready
  );
endinterface : nps_rsp_if

`default_nettype wire

### design/nearest_point_search_isqrt_unit.sv
// A write item's result is registered when the back end takes the command.
// A query scans the table, reading one entry per cycle through the single
// RAM read port; then, if a nearest entry was found, the floor square root
// runs 16 steps, one bit pair per cycle.
// The back end handles one item at a time; the command queue keeps accepting
// while a query runs, as long as it has room. Reset clears active marks, count and queue.
// ----------------------------------------------------------------------------
// nearest_point_search_isqrt_unit
// Nearest active table entry search with integer square root of distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_isqrt_unit #(
  parameter int ENTRIES     = nps_pkg::ENTRIES_DEF,
  parameter int QUEUE_DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  nps_req_if.sink   req,
  nps_rsp_if.source rsp
);
  import nps_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  nps_front u_nps_front (
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_nps_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  nps_back #(
    .ENTRIES (ENTRIES)
  ) u_nps_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule : nearest_point_search_isqrt_unit

`default_nettype wire

### design/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : nps_ram

`default_nettype wire

### design/nps_isqrt.sv
// ----------------------------------------------------------------------------
// nps_isqrt
// Iterative floor square root, one bit pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_isqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nps_pkg::sqrt_req_t req,
  output nps_pkg::sqrt_rsp_t      rsp
);
  import nps_pkg::*;

  logic             busy;
  logic             done;
  logic [RSQ_W-1:0] rem;
  logic [RSQ_W-1:0] root;
  logic [RSQ_W-1:0] bitm;
  logic [RSQ_W:0]   trial;

  assign trial = {1'b0, root} + {1'b0, bitm};

  // Control: busy through the 16 steps, done pulses after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && bitm[0];
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: subtract the trial value when it fits, then shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.value;
      root <= '0;
      bitm <= RSQ_W'(1) << (RSQ_W - 2);
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[RSQ_W-1:0];
        root <= (root >> 1) + bitm;
      end else begin
        root <= root >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root[DIST_W-1:0];

endmodule : nps_isqrt

`default_nettype wire

### design/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Accept request items, clamp the radius, square it and build a command.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_front (
  nps_req_if.sink            req,
  input  wire logic          q_full,
  output logic               push,
  output nps_pkg::cmd_t      push_cmd
);
  import nps_pkg::*;

  logic [RAD_W-1:0] rad_c;

  // Accept whenever the command queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // Clamp the radius so its square stays below 2^31
  assign rad_c = (req.search_radius > RADIUS_CAP) ? RADIUS_CAP : req.search_radius;

  // Classify the item
  always_comb begin
    push_cmd.op     = req.req_type ? OP_QUERY : OP_WRITE;
    push_cmd.index  = req.entry_index;
    push_cmd.x      = req.pos_x;
    push_cmd.z      = req.pos_z;
    push_cmd.active = req.entry_active;
    push_cmd.rad_sq = RSQ_W'(rad_c) * RSQ_W'(rad_c);
  end

endmodule : nps_front

`default_nettype wire

### design/nps_queue.sv
// ----------------------------------------------------------------------------
// nps_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_queue #(
  parameter int DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nps_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output nps_pkg::cmd_t      pop_cmd,
  output logic               empty
);
  import nps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : nps_queue

`default_nettype wire

### design/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Execute commands: table writes, nearest-entry scan and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_back #(
  parameter int ENTRIES = nps_pkg::ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire nps_pkg::cmd_t pop_cmd,
  output logic               pop,
  nps_rsp_if.source          rsp
);
  import nps_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int PT_W  = 2 * COORD_W;

  back_state_t state;
  back_state_t state_next;

  // Table: coordinates in RAM, active marks in flip-flops
  logic [ENTRIES-1:0] active;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [PT_W-1:0]    ram_rdata;

  // Query registers
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qz;
  logic [RSQ_W-1:0]          best_d2;
  logic [IDX_W-1:0]          best_idx;
  logic                      best_found;

  // Scan pipeline
  logic [CNT_W-1:0] issue_cnt;
  logic             issue_go;
  logic             s1_v;
  logic             s1_act;
  logic [IDX_W-1:0] s1_idx;
  logic             s2_v;
  logic [IDX_W-1:0] s2_idx;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_z;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dz;
  logic signed [2*COORD_W+1:0] dx_sq;
  logic signed [2*COORD_W+1:0] dz_sq;
  logic [D2_W-1:0]             d2;
  logic                        scan_end;

  // Square root unit
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  // Result register
  logic                   out_valid;
  logic                   out_found;
  logic [IDX_FIELD_W-1:0] out_index;
  logic [DIST_W-1:0]      out_root;
  logic [CNT_FIELD_W-1:0] out_total;
  logic                   out_free;

  logic wr_ok;

  nps_ram #(
    .WIDTH (PT_W),
    .DEPTH (ENTRIES)
  ) u_nps_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pop_cmd.x, pop_cmd.z}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nps_isqrt u_nps_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // Take a command when idle and the result register is free
  assign out_free = !out_valid || rsp.ready;
  assign pop      = (state == ST_IDLE) && !q_empty && out_free;

  // Write decode: ignore slots beyond the table
  assign wr_ok     = (32'(pop_cmd.index) < ENTRIES);
  assign ram_we    = pop && (pop_cmd.op == OP_WRITE) && wr_ok;
  assign ram_waddr = IDX_W'(pop_cmd.index);

  // Active count after a write
  always_comb begin
    count_next = count;
    if (ram_we) begin
      unique case ({active[ram_waddr], pop_cmd.active})
        2'b01:   count_next = count + 1'b1;
        2'b10:   count_next = count - 1'b1;
        default: count_next = count;
      endcase
    end
  end

  // Scan address issue
  assign issue_go  = (state == ST_SCAN) && (issue_cnt < CNT_W'(ENTRIES));
  assign ram_raddr = issue_cnt[IDX_W-1:0];

  // Squared differences from the RAM read data
  assign dx    = {ram_rdata[PT_W-1], ram_rdata[PT_W-1:COORD_W]} - {qx[COORD_W-1], qx};
  assign dz    = {ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]} - {qz[COORD_W-1], qz};
  assign dx_sq = dx * dx;
  assign dz_sq = dz * dz;

  assign d2       = {1'b0, sq_x} + {1'b0, sq_z};
  assign scan_end = (state == ST_SCAN) && !issue_go && !s1_v && !s2_v;

  assign sq_req.start = scan_end && best_found;
  assign sq_req.value = best_d2;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && (pop_cmd.op == OP_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = best_found ? ST_ROOT : ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (sq_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      count     <= '0;
      issue_cnt <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ram_we) begin
        active[ram_waddr] <= pop_cmd.active;
      end

      // Scan pipeline valids
      if (pop) begin
        issue_cnt <= '0;
      end else if (issue_go) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      s1_v <= issue_go;
      s2_v <= s1_v && s1_act;

      // Result valid: load on completion, drop when taken
      if ((pop && (pop_cmd.op == OP_WRITE)) || (scan_end && !best_found) ||
          ((state == ST_ROOT) && sq_rsp.done)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      qx         <= pop_cmd.x;
      qz         <= pop_cmd.z;
      best_d2    <= pop_cmd.rad_sq;
      best_idx   <= '0;
      best_found <= 1'b0;
    end else if (s2_v && (d2 < D2_W'(best_d2))) begin
      best_d2    <= d2[RSQ_W-1:0];
      best_idx   <= s2_idx;
      best_found <= 1'b1;
    end
    s1_act <= active[ram_raddr];
    s1_idx <= ram_raddr;
    s2_idx <= s1_idx;
    sq_x   <= dx_sq[SQ_W-1:0];
    sq_z   <= dz_sq[SQ_W-1:0];
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && (pop_cmd.op == OP_WRITE)) begin
      out_found <= 1'b0;
      out_index <= '0;
      out_root  <= '0;
      out_total <= CNT_FIELD_W'(count_next);
    end else if (scan_end && !best_found) begin
      out_found <= 1'b0;
      out_index <= '0;
      out_root  <= '0;
      out_total <= CNT_FIELD_W'(count);
    end else if ((state == ST_ROOT) && sq_rsp.done) begin
      out_found <= 1'b1;
      out_index <= IDX_FIELD_W'(best_idx);
      out_root  <= sq_rsp.root;
      out_total <= CNT_FIELD_W'(count);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.nearest_index = out_index;
  assign rsp.distance      = out_root;
  assign rsp.active_total  = out_total;

endmodule : nps_back

`default_nettype wire

### design/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level assertions for the nearest point search unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker #(
  parameter int ENTRIES = nps_pkg::ENTRIES_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic                            rsp_found,
  input wire logic [nps_pkg::IDX_FIELD_W-1:0] rsp_index,
  input wire logic [nps_pkg::DIST_W-1:0]      rsp_distance,
  input wire logic [nps_pkg::CNT_FIELD_W-1:0] rsp_total
);
  import nps_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Miss results carry zero index and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> (rsp_index == '0) && (rsp_distance == '0))
    else $error("miss result with nonzero index or distance");

  // Active count never exceeds the table size
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (ENTRIES > 31) || (32'(rsp_total) <= ENTRIES))
    else $error("active count beyond table size");

endmodule : nps_checker

bind nearest_point_search_isqrt_unit nps_checker #(
  .ENTRIES (ENTRIES)
) u_nps_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_index    (rsp.nearest_index),
  .rsp_distance (rsp.distance),
  .rsp_total    (rsp.active_total)
);

`default_nettype wire
